FILE: hw/rtl/telnet_command_filter_core_macros.svh
// Assertion macros used by the telnet command filter RTL (telnet_command_filter_core).
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef TELNET_COMMAND_FILTER_CORE_MACROS_SVH
`define TELNET_COMMAND_FILTER_CORE_MACROS_SVH

// Check a property on every rising edge outside reset.
`define TCF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define TCF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hw/rtl/tcf_pkg.sv
// Package for the telnet command filter: codes, sizes and the state and result types.
// No dependencies; used by tcf_parser and telnet_command_filter_core.
package tcf_pkg;

  localparam int SUBNEG_DEPTH = 1024;
  localparam int CNT_W        = $clog2(SUBNEG_DEPTH + 1);
  localparam int HEAD_LEN     = 5;
  localparam int HEAD_IDX_W   = $clog2(HEAD_LEN);

  localparam int IN_TDATA_W   = 8;
  localparam int OUT_TDATA_W  = 48;
  localparam int OUT_PAD_W    = OUT_TDATA_W - 43;

  localparam logic [7:0] CODE_IAC  = 8'd255;
  localparam logic [7:0] CODE_DONT = 8'd254;
  localparam logic [7:0] CODE_DO   = 8'd253;
  localparam logic [7:0] CODE_WONT = 8'd252;
  localparam logic [7:0] CODE_WILL = 8'd251;
  localparam logic [7:0] CODE_SB   = 8'd250;
  localparam logic [7:0] CODE_SE   = 8'd240;
  localparam logic [7:0] OPT_NAWS  = 8'd31;

  // Bit positions in the pending verb flags
  localparam int VERB_DONT = 0;
  localparam int VERB_DO   = 1;
  localparam int VERB_WONT = 2;
  localparam int VERB_WILL = 3;

  localparam logic [15:0] WIDTH_RST  = 16'd80;
  localparam logic [15:0] HEIGHT_RST = 16'd25;

  typedef struct packed {
    logic                          escape_seen;
    logic                          in_subneg;
    logic [CNT_W-1:0]              count;
    logic [HEAD_LEN-1:0][7:0]      head;
    logic [3:0]                    verbs;
    logic [15:0]                   width;
    logic [15:0]                   height;
  } tcf_state_t;

  typedef struct packed {
    logic        overflow_error;
    logic        size_update;
    logic [15:0] window_height;
    logic [15:0] window_width;
    logic [7:0]  data_byte;
    logic        data_valid;
  } tcf_result_t;

endpackage

FILE: hw/rtl/telnet_command_filter_core.sv
// Telnet command filter: strips IAC commands from a byte stream and tracks NAWS size.
// Top level; depends on tcf_pkg, tcf_parser and telnet_command_filter_core_macros.svh.
// Registered output: the result shows on out_tvalid in the cycle after input accept.
// Throughput: one byte per cycle while out_tready is high; the output register is refilled in the cycle it drains.
// Reset (rst_n low, synchronous): no result pending, all flags and counts clear,
// window size 80 x 25; in_tready is low while reset is held.
`include "telnet_command_filter_core_macros.svh"

module telnet_command_filter_core
  import tcf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] rx_byte
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] data_valid, [8:1] data_byte, [24:9] window_width, [40:25] window_height,
  // [41] size_update, [42] overflow_error, [47:43] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  tcf_state_t  state_r, state_nxt;
  tcf_result_t res_nxt, res_r;
  logic        out_valid_r, out_valid_nxt;
  logic        in_accept;

  tcf_parser u_parser (
    .state_i  (state_r),
    .rx_byte  (in_tdata[7:0]),
    .state_o  (state_nxt),
    .result_o (res_nxt)
  );

  assign in_tready     = rst_n && (!out_valid_r || out_tready);
  assign in_accept     = in_tvalid && in_tready;
  assign out_valid_nxt = in_accept || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r         <= 1'b0;
      state_r.escape_seen <= 1'b0;
      state_r.in_subneg   <= 1'b0;
      state_r.count       <= '0;
      state_r.head        <= '0;
      state_r.verbs       <= '0;
      state_r.width       <= WIDTH_RST;
      state_r.height      <= HEIGHT_RST;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_accept) begin
        state_r <= state_nxt;
      end
    end
  end

  // hold the result until taken
  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, res_r};

  `TCF_ASSERT(a_count_idle, !state_r.in_subneg |-> state_r.count == '0, "count nonzero outside subnegotiation")
  `TCF_ASSERT(a_ovf_aborts, in_accept && res_nxt.overflow_error |=> !state_r.in_subneg, "overflow did not abort subnegotiation")
  `TCF_ASSERT(a_size_stable, !(in_accept && res_nxt.size_update) |=> $stable(state_r.width) && $stable(state_r.height), "window size changed without update")
  `TCF_ASSERT(a_excl_flags, out_tvalid |-> !(res_r.data_valid && (res_r.size_update || res_r.overflow_error)), "data and command flags together")
  `TCF_ASSERT_ALWAYS(a_no_accept_rst, !rst_n |-> !in_tready, "input ready during reset")

endmodule

FILE: hw/rtl/tcf_parser.sv
// Per-byte telnet command decoder: next filter state and the result for one item.
// Pure combinational logic; depends on tcf_pkg.
module tcf_parser
  import tcf_pkg::*;
(
  input  tcf_state_t  state_i,
  input  logic [7:0]  rx_byte,
  output tcf_state_t  state_o,
  output tcf_result_t result_o
);

  logic             dv;
  logic             upd;
  logic             ovf;
  logic [CNT_W-1:0] cnt_inc;

  assign cnt_inc = state_i.count + CNT_W'(1);

  always_comb begin
    state_o = state_i;
    dv      = 1'b0;
    upd     = 1'b0;
    ovf     = 1'b0;

    if (rx_byte == CODE_IAC && !state_i.escape_seen) begin
      state_o.escape_seen = 1'b1;
    end else if (rx_byte != CODE_IAC && state_i.escape_seen) begin
      state_o.escape_seen = 1'b0;
      case (rx_byte)
        CODE_SB: begin
          state_o.count     = '0;
          state_o.in_subneg = 1'b1;
        end
        CODE_SE: begin
          if (state_i.in_subneg) begin
            if (state_i.count >= CNT_W'(HEAD_LEN) && state_i.head[0] == OPT_NAWS) begin
              state_o.width  = {state_i.head[1], state_i.head[2]};
              state_o.height = {state_i.head[3], state_i.head[4]};
              upd            = 1'b1;
            end
            state_o.count     = '0;
            state_o.in_subneg = 1'b0;
          end
        end
        CODE_DONT: state_o.verbs[VERB_DONT] = 1'b1;
        CODE_DO:   state_o.verbs[VERB_DO]   = 1'b1;
        CODE_WONT: state_o.verbs[VERB_WONT] = 1'b1;
        CODE_WILL: state_o.verbs[VERB_WILL] = 1'b1;
        default: ;
      endcase
    end else begin
      // plain byte or second half of a doubled IAC
      state_o.escape_seen = 1'b0;
      if (state_i.in_subneg) begin
        if (state_i.count < CNT_W'(HEAD_LEN)) begin
          state_o.head[state_i.count[HEAD_IDX_W-1:0]] = rx_byte;
        end
        if (cnt_inc >= CNT_W'(SUBNEG_DEPTH)) begin
          ovf               = 1'b1;
          state_o.count     = '0;
          state_o.in_subneg = 1'b0;
        end else begin
          state_o.count = cnt_inc;
        end
      end else if (state_i.verbs[VERB_DONT]) begin
        state_o.verbs[VERB_DONT] = 1'b0;
      end else if (state_i.verbs[VERB_DO]) begin
        state_o.verbs[VERB_DO] = 1'b0;
      end else if (state_i.verbs[VERB_WONT]) begin
        state_o.verbs[VERB_WONT] = 1'b0;
      end else if (state_i.verbs[VERB_WILL]) begin
        state_o.verbs[VERB_WILL] = 1'b0;
      end else begin
        dv = 1'b1;
      end
    end
  end

  always_comb begin
    result_o.data_valid     = dv;
    result_o.data_byte      = dv ? rx_byte : 8'd0;
    result_o.window_width   = state_o.width;
    result_o.window_height  = state_o.height;
    result_o.size_update    = upd;
    result_o.overflow_error = ovf;
  end

endmodule
